FILE: rtl/core/buck_boost_duty_regulator_core_defines.svh
// Assertion macros for the buck/boost duty regulator core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BUCK_BOOST_DUTY_REGULATOR_CORE_DEFINES_SVH
`define BUCK_BOOST_DUTY_REGULATOR_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication under a synchronous reset.
`define BBDR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbdr assertion failed");
// Next-cycle implication under a synchronous reset.
`define BBDR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbdr assertion failed");
`else
`define BBDR_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBDR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/bbdr_pkg.sv
// Shared types and constants of the buck/boost duty regulator core.
// No dependencies; used by every module of the core.
`default_nettype none

package bbdr_pkg;

   // Converter modes, also the encoding of current_mode and requested_mode.
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TRANS = 2'd1,
      MODE_BUCK  = 2'd2,
      MODE_BOOST = 2'd3
   } mode_type;

   // Item classes decided by the front end.
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_SKIP  = 2'd1,
      KIND_RUN   = 2'd2
   } kind_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MAX_DUTY    = 3'd0;
   localparam logic [2:0] CSR_MIN_BUCK    = 3'd1;
   localparam logic [2:0] CSR_BOOST_FLOOR = 3'd2;
   localparam logic [2:0] CSR_PROBE_DUTY  = 3'd3;
   localparam logic [2:0] CSR_BYPASS      = 3'd4;

   // Register reset values before masking to the duty width.
   localparam logic [15:0] MAX_DUTY_RESET    = 16'd1199;
   localparam logic [15:0] MIN_BUCK_RESET    = 16'd25;
   localparam logic [15:0] BOOST_FLOOR_RESET = 16'd200;
   localparam logic [15:0] PROBE_DUTY_RESET  = 16'd120;

   // Load status codes that force the probe clamp.
   localparam logic [2:0] LOAD_OPEN  = 3'd0;
   localparam logic [2:0] LOAD_SHORT = 3'd1;

   // Voltage scale: volts = (adc * VOLT_SCALE) >> 12.
   localparam logic [10:0] VOLT_SCALE = 11'd1109;

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration as seen by the back end, already masked to the duty width.
   typedef struct packed {
      logic [15:0] max_duty;
      logic [15:0] min_buck;
      logic [15:0] boost_floor;
      logic [15:0] probe_duty;
      logic        bypass;
   } cfg_type;

   // One classified item passed from front to back.
   typedef struct packed {
      kind_type    kind;
      logic [10:0] volts;
      logic        vol_lt;
      logic        vol_gt;
      logic        batt_low;
      logic        clamp;
   } entry_type;

   // One result item.
   typedef struct packed {
      logic        ran;
      logic [10:0] volts;
      mode_type    cur_mode;
      mode_type    req_mode;
      logic [15:0] buck_duty;
      logic [15:0] boost_duty;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/bbdr_front.sv
// Front end: takes input transfers, scales the sample and classifies the item.
// Depends on bbdr_pkg; feeds bbdr_queue.
`default_nettype none

module bbdr_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [39:0]         req_tdata,
   input  wire logic                req_tuser,
   output logic                     q_valid,
   input  wire logic                q_ready,
   output bbdr_pkg::entry_type      q_data
);

   logic                stage_valid_ff;
   logic                stage_valid_in;
   bbdr_pkg::entry_type stage_ff;
   bbdr_pkg::entry_type stage_in;

   logic [11:0] adc;
   logic [9:0]  target;
   logic [9:0]  battery;
   logic        firing;
   logic        probing;
   logic        bat_fault;
   logic [2:0]  status;
   logic        late;
   logic [22:0] product;
   logic [10:0] volts;
   logic [13:0] target_x12;
   logic [13:0] battery_x10;
   logic        accept;

   // Unpack the input transfer.
   assign adc       = req_tdata[11:0];
   assign target    = req_tdata[21:12];
   assign battery   = req_tdata[31:22];
   assign firing    = req_tdata[32];
   assign probing   = req_tdata[33];
   assign bat_fault = req_tdata[34];
   assign status    = req_tdata[37:35];
   assign late      = req_tdata[38];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !stage_valid_ff || q_ready;

   // Scale the sample into 10 mV units and compare against the target.
   assign product     = 23'(adc) * 23'(bbdr_pkg::VOLT_SCALE);
   assign volts       = product[22:12];
   assign target_x12  = 14'(target) * 14'd12;
   assign battery_x10 = 14'(battery) * 14'd10;

   // Classify the item.
   always_comb begin
      stage_in          = '0;
      stage_in.vol_lt   = volts < 11'(target);
      stage_in.vol_gt   = volts > 11'(target);
      stage_in.batt_low = target_x12 > battery_x10;
      stage_in.clamp    = (status == bbdr_pkg::LOAD_OPEN) ||
                          (status == bbdr_pkg::LOAD_SHORT) || (!firing && late);
      priority if (req_tuser) begin
         stage_in.kind = bbdr_pkg::KIND_START;
      end else if ((firing && !bat_fault) || (!firing && probing)) begin
         stage_in.kind  = bbdr_pkg::KIND_RUN;
         stage_in.volts = volts;
      end else begin
         stage_in.kind = bbdr_pkg::KIND_SKIP;
      end
   end

   // Stage register valid flag.
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (q_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign q_valid = stage_valid_ff;
   assign q_data  = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bbdr_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on bbdr_pkg and the core assertion macros.
`default_nettype none
`include "buck_boost_duty_regulator_core_defines.svh"

module bbdr_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire bbdr_pkg::entry_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output bbdr_pkg::entry_type      out_data
);

   localparam int DEPTH = bbdr_pkg::QUEUE_DEPTH;

   bbdr_pkg::entry_type                entries_ff [DEPTH];
   logic [bbdr_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [bbdr_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [bbdr_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [bbdr_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [bbdr_pkg::QCNT_W-1:0]        count_ff;
   logic [bbdr_pkg::QCNT_W-1:0]        count_in;
   logic                               push;
   logic                               pop;

   assign in_ready  = count_ff < bbdr_pkg::QCNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bbdr_pkg::QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bbdr_pkg::QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Occupancy never exceeds the depth, and an empty queue keeps both pointers together.
   `BBDR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= bbdr_pkg::QCNT_W'(DEPTH))
   `BBDR_ASSERT_IMP(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)
   // A full queue refuses writes until something drains.
   `BBDR_ASSERT_NXT(a_full_hold, clock, reset, !in_ready && !out_ready, !in_ready)

endmodule

`default_nettype wire

FILE: rtl/core/bbdr_back.sv
// Back end: converter mode machine and duty registers, with the result register.
// Depends on bbdr_pkg and the core assertion macros; fed by bbdr_queue.
`default_nettype none
`include "buck_boost_duty_regulator_core_defines.svh"

module bbdr_back #(
   parameter int DUTY_WIDTH     = 16,
   parameter int MISMATCH_LIMIT = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bbdr_pkg::cfg_type   cfg,
   input  wire logic                q_valid,
   output logic                     q_ready,
   input  wire bbdr_pkg::entry_type q_data,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output bbdr_pkg::result_type     rsp_data
);

   bbdr_pkg::mode_type     mode_ff;
   bbdr_pkg::mode_type     mode_in;
   bbdr_pkg::mode_type     next_mode_ff;
   bbdr_pkg::mode_type     next_mode_in;
   logic [7:0]             mismatch_ff;
   logic [7:0]             mismatch_in;
   logic [DUTY_WIDTH-1:0]  buck_ff;
   logic [DUTY_WIDTH-1:0]  buck_in;
   logic [DUTY_WIDTH-1:0]  boost_ff;
   logic [DUTY_WIDTH-1:0]  boost_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   bbdr_pkg::result_type   rsp_ff;
   bbdr_pkg::result_type   rsp_in;
   logic                   pop;
   logic [DUTY_WIDTH-1:0]  max_d;
   logic [DUTY_WIDTH-1:0]  min_b;
   logic [DUTY_WIDTH-1:0]  floor_b;
   logic [DUTY_WIDTH-1:0]  probe_d;

   assign max_d   = cfg.max_duty[DUTY_WIDTH-1:0];
   assign min_b   = cfg.min_buck[DUTY_WIDTH-1:0];
   assign floor_b = cfg.boost_floor[DUTY_WIDTH-1:0];
   assign probe_d = cfg.probe_duty[DUTY_WIDTH-1:0];

   // Take an item whenever the result register is free or being drained.
   assign pop     = q_valid && (!rsp_valid_ff || rsp_tready);
   assign q_ready = !rsp_valid_ff || rsp_tready;

   // One converter step for the item at the head of the queue.
   always_comb begin
      next_mode_in = next_mode_ff;
      mode_in      = mode_ff;
      mismatch_in  = mismatch_ff;
      buck_in      = buck_ff;
      boost_in     = boost_ff;
      if (pop) begin
         unique case (q_data.kind)
            bbdr_pkg::KIND_START: begin
               next_mode_in = bbdr_pkg::MODE_BUCK;
               mode_in      = bbdr_pkg::MODE_IDLE;
            end
            bbdr_pkg::KIND_RUN: begin
               unique case (next_mode_ff)
                  bbdr_pkg::MODE_TRANS: begin
                     // Debounce mismatches before picking buck or boost.
                     if (!q_data.vol_lt && !q_data.vol_gt) begin
                        mismatch_in = '0;
                     end else begin
                        mismatch_in = mismatch_ff + 8'd1;
                        if (mismatch_in >= 8'(MISMATCH_LIMIT)) begin
                           if (!cfg.bypass) begin
                              next_mode_in = (mode_ff == bbdr_pkg::MODE_BUCK) ?
                                             bbdr_pkg::MODE_BOOST : bbdr_pkg::MODE_BUCK;
                           end
                           mode_in = bbdr_pkg::MODE_TRANS;
                        end
                     end
                  end
                  bbdr_pkg::MODE_BUCK: begin
                     // Preset on entry, step one toward target; 0 at min_buck.
                     if (mode_ff != bbdr_pkg::MODE_BUCK) begin
                        buck_in = (mode_ff == bbdr_pkg::MODE_IDLE) ? min_b : max_d;
                        mode_in = bbdr_pkg::MODE_BUCK;
                     end
                     if (q_data.vol_lt) begin
                        if (buck_in < max_d) begin
                           buck_in = buck_in + 1'b1;
                        end else if (q_data.batt_low) begin
                           next_mode_in = bbdr_pkg::MODE_TRANS;
                        end
                     end else if (q_data.vol_gt) begin
                        if (buck_in > min_b) begin
                           buck_in = buck_in - 1'b1;
                        end else begin
                           buck_in = '0;
                        end
                     end
                     // Open or shorted load, or a late probe, caps the duty.
                     if (q_data.clamp && (buck_in >= probe_d)) begin
                        buck_in = probe_d;
                     end
                  end
                  bbdr_pkg::MODE_BOOST: begin
                     if (mode_ff != bbdr_pkg::MODE_BOOST) begin
                        mode_in  = bbdr_pkg::MODE_BOOST;
                        boost_in = max_d;
                     end
                     if (q_data.vol_lt && (boost_in > floor_b)) begin
                        boost_in = boost_in - 1'b1;
                     end else if (q_data.vol_gt) begin
                        if (boost_in < max_d) begin
                           boost_in = boost_in + 1'b1;
                        end else begin
                           next_mode_in = bbdr_pkg::MODE_TRANS;
                        end
                     end
                  end
                  default: begin
                     // Requested idle: the voltage is reported, no state moves.
                  end
               endcase
            end
            default: begin
               // Skipped tick.
            end
         endcase
      end
   end

   // Result assembly and output register control.
   always_comb begin
      rsp_in            = '0;
      rsp_in.ran        = q_data.kind == bbdr_pkg::KIND_RUN;
      rsp_in.volts      = q_data.volts;
      rsp_in.cur_mode   = mode_in;
      rsp_in.req_mode   = next_mode_in;
      rsp_in.buck_duty  = 16'(buck_in);
      rsp_in.boost_duty = 16'(boost_in);
      rsp_valid_in      = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bbdr_pkg::MODE_IDLE;
         next_mode_ff <= bbdr_pkg::MODE_IDLE;
         mismatch_ff  <= '0;
         buck_ff      <= '0;
         boost_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         next_mode_ff <= next_mode_in;
         mismatch_ff  <= mismatch_in;
         buck_ff      <= buck_in;
         boost_ff     <= boost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // A start item leaves the converter idle with buck requested.
   `BBDR_ASSERT_NXT(a_start_modes, clock, reset, pop && (q_data.kind == bbdr_pkg::KIND_START), (mode_ff == bbdr_pkg::MODE_IDLE) && (next_mode_ff == bbdr_pkg::MODE_BUCK))
   // A skipped tick touches neither duty nor the mismatch counter.
   `BBDR_ASSERT_NXT(a_skip_stable, clock, reset, pop && (q_data.kind == bbdr_pkg::KIND_SKIP), $stable(buck_ff) && $stable(boost_ff) && $stable(mismatch_ff))
   // Every taken item shows up in the result register on the next cycle.
   `BBDR_ASSERT_NXT(a_pop_result, clock, reset, pop, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: rtl/core/buck_boost_duty_regulator_core.sv
// Buck/boost duty regulator: one start command or regulation tick per input
// transfer, one result transfer per item. The front end scales the ADC sample
// and classifies the item, a two-entry queue decouples it from the back end,
// which runs the transition/buck/boost mode step combinationally and holds the
// result in an output register. Sustained rate is one item per clock while the
// result channel is not stalled. An input transfer passes through the front-end
// stage register, the queue and the result register before rsp_tvalid rises.
// Configuration writes are taken in any cycle (csr_ready is always high) and must
// be made while no item is in flight. There is no clearing pass after reset.
// Depends on bbdr_pkg, bbdr_front, bbdr_queue and bbdr_back.
`default_nettype none

module buck_boost_duty_regulator_core #(
   parameter int DUTY_WIDTH     = 16,
   parameter int MISMATCH_LIMIT = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata from bit 0: adc_sample[11:0], target_volts[21:12], battery_volts[31:22],
   // firing[32], probing[33], battery_fault[34], load_status[37:35],
   // late_probe[38], zero[39].
   input  wire logic [39:0] req_tdata,
   // tuser: command.
   input  wire logic        req_tuser,
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata from bit 0: out_volts[10:0], current_mode[12:11], requested_mode[14:13],
   // buck_duty[30:15], boost_duty[46:31], zero[47].
   output logic [47:0]      rsp_tdata,
   // tuser: ran.
   output logic             rsp_tuser,
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam logic [DUTY_WIDTH-1:0] MAX_DUTY_RST    =
      bbdr_pkg::MAX_DUTY_RESET[DUTY_WIDTH-1:0];
   localparam logic [DUTY_WIDTH-1:0] MIN_BUCK_RST    =
      bbdr_pkg::MIN_BUCK_RESET[DUTY_WIDTH-1:0];
   localparam logic [DUTY_WIDTH-1:0] BOOST_FLOOR_RST =
      bbdr_pkg::BOOST_FLOOR_RESET[DUTY_WIDTH-1:0];
   localparam logic [DUTY_WIDTH-1:0] PROBE_DUTY_RST  =
      bbdr_pkg::PROBE_DUTY_RESET[DUTY_WIDTH-1:0];

   logic [DUTY_WIDTH-1:0] max_duty_ff;
   logic [DUTY_WIDTH-1:0] min_buck_ff;
   logic [DUTY_WIDTH-1:0] boost_floor_ff;
   logic [DUTY_WIDTH-1:0] probe_duty_ff;
   logic                  bypass_ff;
   logic                  csr_write;
   bbdr_pkg::cfg_type     cfg;

   logic                  q_in_valid;
   logic                  q_in_ready;
   bbdr_pkg::entry_type   q_in_data;
   logic                  q_out_valid;
   logic                  q_out_ready;
   bbdr_pkg::entry_type   q_out_data;
   bbdr_pkg::result_type  result;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff    <= MAX_DUTY_RST;
         min_buck_ff    <= MIN_BUCK_RST;
         boost_floor_ff <= BOOST_FLOOR_RST;
         probe_duty_ff  <= PROBE_DUTY_RST;
         bypass_ff      <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            bbdr_pkg::CSR_MAX_DUTY:    max_duty_ff    <= csr_data[DUTY_WIDTH-1:0];
            bbdr_pkg::CSR_MIN_BUCK:    min_buck_ff    <= csr_data[DUTY_WIDTH-1:0];
            bbdr_pkg::CSR_BOOST_FLOOR: boost_floor_ff <= csr_data[DUTY_WIDTH-1:0];
            bbdr_pkg::CSR_PROBE_DUTY:  probe_duty_ff  <= csr_data[DUTY_WIDTH-1:0];
            bbdr_pkg::CSR_BYPASS:      bypass_ff      <= csr_data[0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   assign cfg.max_duty    = 16'(max_duty_ff);
   assign cfg.min_buck    = 16'(min_buck_ff);
   assign cfg.boost_floor = 16'(boost_floor_ff);
   assign cfg.probe_duty  = 16'(probe_duty_ff);
   assign cfg.bypass      = bypass_ff;

   // Front end: scaling and classification.
   bbdr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_in_valid),
      .q_ready    (q_in_ready),
      .q_data     (q_in_data)
   );

   // Queue between the two halves.
   bbdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   // Back end: mode machine, duty registers and result register.
   bbdr_back #(
      .DUTY_WIDTH     (DUTY_WIDTH),
      .MISMATCH_LIMIT (MISMATCH_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_out_valid),
      .q_ready    (q_out_ready),
      .q_data     (q_out_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (result)
   );

   // Pack the result transfer.
   assign rsp_tuser        = result.ran;
   assign rsp_tdata[10:0]  = result.volts;
   assign rsp_tdata[12:11] = result.cur_mode;
   assign rsp_tdata[14:13] = result.req_mode;
   assign rsp_tdata[30:15] = result.buck_duty;
   assign rsp_tdata[46:31] = result.boost_duty;
   assign rsp_tdata[47]    = 1'b0;

endmodule

`default_nettype wire
